// ===== hdl/rnt_pkg.sv =====
// Shared types and codes of the RSSI neighbour table.
// Used by rnt_cell and rssi_neighbor_table_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rnt_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int AVG_LEN_DEF     = 5;

  // Width of the entries_used result field
  localparam int ENT_W = 5;

  // Reset value of the selection threshold
  localparam logic signed [7:0] THRESH_RESET = -8'sd80;

  // Operation codes
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_SELECTED = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  localparam logic signed [7:0] AVG_MIN = -8'sd128;

  typedef struct packed {
    logic [1:0]         func;
    logic [47:0]        peer_address;
    logic               peer_address_type;
    logic signed [7:0]  signal_strength;
    logic               may_connect;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [47:0]        chosen_address;
    logic               chosen_address_type;
    logic signed [7:0]  chosen_strength;
    logic [ENT_W-1:0]   entries_used;
  } out_item_t;

  // Request token that walks the row of slot cells
  typedef struct packed {
    logic               valid;
    logic [1:0]         func;
    logic [47:0]        addr;
    logic               atype;
    logic signed [7:0]  strength;
    logic               allow;
    logic               hit;
    logic               found;
    logic signed [7:0]  best_avg;
    logic [47:0]        best_addr;
    logic               best_atype;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/rnt_cell.sv =====
// One slot of the neighbour table: holds a peer and passes the request token on.
// Depends on rnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rnt_cell #(
  parameter int AVG_LEN = 5,
  parameter int INDEX   = 0,
  parameter int FILL_W  = 5,
  parameter int IDX_W   = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [FILL_W-1:0]   fill,
  input  wire rnt_pkg::tok_t       tok_in,
  input  wire logic [IDX_W-1:0]    idx_in,
  input  wire logic                mark_en,
  input  wire logic [IDX_W-1:0]    mark_idx,
  output rnt_pkg::tok_t            tok_out,
  output logic [IDX_W-1:0]         idx_out
);
  import rnt_pkg::*;

  localparam int CNT_W = $clog2(AVG_LEN + 1);
  localparam int N_W   = 9 + $clog2(AVG_LEN);
  localparam int SH    = N_W;
  localparam int P_W   = N_W + SH + 1;
  localparam int RECIP = (2 ** SH) / AVG_LEN;

  logic [47:0]        addr;
  logic               atype;
  logic signed [7:0]  avg;
  logic [CNT_W-1:0]   cnt;
  logic               chosen;

  logic               occupied;
  logic               is_free;
  logic               match;
  logic               ins;
  logic               better;

  logic signed [8:0]  hsum;
  logic [8:0]         hadj;
  logic signed [7:0]  half;
  logic signed [N_W-1:0] wsum;
  logic               wneg;
  logic [N_W-1:0]     wmag;
  logic [P_W-1:0]     prod;
  logic [N_W-1:0]     qest;
  logic [N_W-1:0]     rem;
  logic [N_W-1:0]     q;
  logic signed [7:0]  weighted;
  logic signed [7:0]  avg_next;
  tok_t               tok_next;

  assign occupied = FILL_W'(INDEX) < fill;
  assign is_free  = FILL_W'(INDEX) == fill;
  assign match    = tok_in.valid && tok_in.func == FUNC_REPORT && occupied && !tok_in.hit
                    && addr == tok_in.addr && atype == tok_in.atype;
  assign ins      = tok_in.valid && tok_in.func == FUNC_REPORT && is_free && !tok_in.hit;
  assign better   = tok_in.valid && tok_in.func == FUNC_SELECT && occupied && !chosen
                    && avg > tok_in.best_avg;

  // Halving average, truncated toward zero
  always_comb begin
    hsum = 9'(avg) + 9'(tok_in.strength);
    hadj = hsum + 9'(hsum[8]);
    half = hadj[8:1];
  end

  // Weighted average: divide by AVG_LEN through a reciprocal and one correction
  always_comb begin
    wsum = N_W'(N_W'(avg) * (AVG_LEN - 1) + tok_in.strength);
    wneg = wsum[N_W-1];
    wmag = wneg ? N_W'(-wsum) : N_W'(wsum);
    prod = P_W'(wmag) * P_W'(RECIP);
    qest = prod[SH+N_W-1:SH];
    rem  = wmag - N_W'(qest * AVG_LEN);
    q    = (rem >= N_W'(AVG_LEN)) ? qest + N_W'(1) : qest;
    weighted = wneg ? -q[7:0] : q[7:0];
  end

  assign avg_next = (cnt < CNT_W'(AVG_LEN)) ? half : weighted;

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit = 1'b1;
    end
    if (better) begin
      tok_next.found      = 1'b1;
      tok_next.best_avg   = avg;
      tok_next.best_addr  = addr;
      tok_next.best_atype = atype;
    end
  end

  // Slot contents: no reset, only slots below the fill count are looked at
  always_ff @(posedge clk) begin
    if (ins) begin
      addr   <= tok_in.addr;
      atype  <= tok_in.atype;
      avg    <= tok_in.strength;
      cnt    <= CNT_W'(1);
      chosen <= 1'b0;
    end else if (match) begin
      avg <= avg_next;
      if (cnt < CNT_W'(AVG_LEN)) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
    if (mark_en && mark_idx == IDX_W'(INDEX)) begin
      chosen <= 1'b1;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      idx_out <= '0;
    end else begin
      tok_out <= tok_next;
      idx_out <= better ? IDX_W'(INDEX) : idx_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rssi_neighbor_table_top.sv =====
// Top level of the RSSI neighbour table: handshakes, the row of slot cells,
// the result register and the control sequence. Depends on rnt_pkg and rnt_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a table of up to TABLE_DEPTH radio peers, filled in arrival
// order. Each accepted item is a request token that walks a row of TABLE_DEPTH
// slot cells, one cell per clock: a report updates the matching slot's signal
// average, claims the first free slot or is dropped when the table is full, a
// select gathers the strongest peer not yet chosen, and a clear empties the
// table. The token leaving the last cell is resolved into a hold register and
// then loaded into the output register once that is free; the next item is
// taken only once that result sits in the output register, so the block takes
// no new item while one is still in flight. An item with the unused operation
// code is taken and gives no result.
// The threshold register (reset -80) is written through the cfg channel, which
// is always ready; write it only while no request is in flight. There is no
// clearing pass after reset: the table starts empty.
module rssi_neighbor_table_top #(
  parameter int TABLE_DEPTH = rnt_pkg::TABLE_DEPTH_DEF,
  parameter int AVG_LEN     = rnt_pkg::AVG_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rnt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rnt_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [7:0]  cfg_data
);
  import rnt_pkg::*;

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t             state;
  state_t             state_next;

  logic signed [7:0]  thresh;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;

  tok_t               tok_link [TABLE_DEPTH+1];
  logic [IDX_W-1:0]   idx_link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] tok_valids;

  tok_t               tail;
  logic [IDX_W-1:0]   tail_idx;
  logic               tail_done;

  out_item_t          res;
  out_item_t          res_hold;
  logic               sel_ok;
  logic               mark_en;
  logic               in_xfer;
  logic               out_load;

  // Configuration: the channel never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  assign in_xfer = in_valid && in_ready;

  // Launch the token into the first cell on the transfer; drop unused codes here
  always_comb begin
    tok_link[0]            = '0;
    tok_link[0].valid      = in_xfer && in_data.func != FUNC_NOP;
    tok_link[0].func       = in_data.func;
    tok_link[0].addr       = in_data.peer_address;
    tok_link[0].atype      = in_data.peer_address_type;
    tok_link[0].strength   = in_data.signal_strength;
    tok_link[0].allow      = in_data.may_connect;
    tok_link[0].best_avg   = AVG_MIN;
    idx_link[0]            = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rnt_cell #(
      .AVG_LEN (AVG_LEN),
      .INDEX   (i),
      .FILL_W  (FILL_W),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .fill     (fill),
      .tok_in   (tok_link[i]),
      .idx_in   (idx_link[i]),
      .mark_en  (mark_en),
      .mark_idx (tail_idx),
      .tok_out  (tok_link[i+1]),
      .idx_out  (idx_link[i+1])
    );
    assign tok_valids[i] = tok_link[i+1].valid;
  end

  assign tail      = tok_link[TABLE_DEPTH];
  assign tail_idx  = idx_link[TABLE_DEPTH];
  assign tail_done = state == S_WALK && tail.valid;

  // Resolve the token leaving the last cell into a result
  always_comb begin
    res       = '0;
    fill_next = fill;
    sel_ok    = tail.found && tail.best_avg > thresh && tail.allow;
    unique case (tail.func)
      FUNC_REPORT: begin
        if (tail.hit) begin
          res.status = ST_UPDATED;
        end else if (fill < FILL_W'(TABLE_DEPTH)) begin
          res.status = ST_INSERTED;
          fill_next  = fill + FILL_W'(1);
        end else begin
          res.status = ST_DROPPED;
        end
      end
      FUNC_SELECT: begin
        if (sel_ok) begin
          res.status              = ST_SELECTED;
          res.chosen_address      = tail.best_addr;
          res.chosen_address_type = tail.best_atype;
          res.chosen_strength     = tail.best_avg;
        end else begin
          res.status = ST_NONE;
        end
      end
      FUNC_CLEAR: begin
        res.status = ST_CLEARED;
        fill_next  = '0;
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
    res.entries_used = ENT_W'(fill_next);
  end

  // Mark the selected slot as chosen as the token leaves the row
  assign mark_en = tail_done && tail.func == FUNC_SELECT && sel_ok;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && in_data.func != FUNC_NOP) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (tail.valid) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequence
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_WALK: begin
        in_ready = 1'b0;
      end
      S_PUSH: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (tail_done) begin
        fill <= fill_next;
      end
    end
  end

  // Hold the resolved result until the output register is free
  always_ff @(posedge clk) begin
    if (tail_done) begin
      res_hold <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res_hold;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one token in the cell row");

  a_fill_quiet : assert property (@(posedge clk) disable iff (rst)
    !tail_done |=> $stable(fill))
    else $error("fill count moved without a finished walk");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    tail_done && tail.func == FUNC_REPORT && !tail.hit && fill < FILL_W'(TABLE_DEPTH)
    |=> fill == $past(fill) + FILL_W'(1))
    else $error("insert did not grow the table");

  a_token_idle : assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> tok_valids == '0)
    else $error("token in the row while idle");
`endif

endmodule

`default_nettype wire
